// ----- src/positional_list_engine_macros.svh -----
// Assertion macros shared by the positional list engine RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// Used by ple_cell and positional_list_engine; depends on nothing.
`default_nettype none

package ple_pkg;

    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SORT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    typedef logic [2:0] cell_op_t;

    localparam cell_op_t CELL_HOLD  = 3'd0;
    localparam cell_op_t CELL_LOAD  = 3'd1;
    localparam cell_op_t CELL_LEFT  = 3'd2;
    localparam cell_op_t CELL_RIGHT = 3'd3;
    localparam cell_op_t CELL_WRAP  = 3'd4;
    localparam cell_op_t CELL_SORT  = 3'd5;

    typedef struct packed {
        cell_op_t op;
        logic     left_act;
        logic     right_act;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/ple_cell.sv -----
// One storage cell of the list chain: holds one element and trades it with its neighbors.
// Depends on ple_pkg for the cell control struct and operation codes.
`default_nettype none

module ple_cell
    import ple_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [VAL_W-1:0]  load_value,
    input  wire logic [VAL_W-1:0]  left_value,
    input  wire logic [VAL_W-1:0]  right_value,
    input  wire logic [VAL_W-1:0]  wrap_value,
    input  wire logic              left_gt,
    output logic [VAL_W-1:0]       value,
    output logic                   gt
);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    assign value = value_reg;
    assign gt    = $signed(value_reg) > $signed(right_value);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_HOLD:  value_next = value_reg;
            CELL_LOAD:  value_next = load_value;
            CELL_LEFT:  value_next = left_value;
            CELL_RIGHT: value_next = right_value;
            CELL_WRAP:  value_next = wrap_value;
            CELL_SORT:
            begin
                if (ctrl.right_act && gt)
                begin
                    value_next = right_value;
                end
                else if (ctrl.left_act && left_gt)
                begin
                    value_next = left_value;
                end
            end
            default:    value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- src/positional_list_engine.sv -----
// Insert and delete present their result in the cycle after acceptance; an empty dump likewise.
// Sort runs one odd-even phase per cycle over the cell chain, then a finish state loads the result.
// Dump emits one word per unstalled cycle from the head cell while the chain rotates. A new word
// is taken once the previous command has placed its last result and the output register is empty or unstalled.
// Reset clears the length to zero; element contents are unspecified until written.
`default_nettype none

`include "positional_list_engine_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [VAL_W-1:0]  value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ST_W-1:0]        status,
    output logic                   has_value,
    output logic [VAL_W-1:0]       element_value,
    output logic [LEN_W-1:0]       list_length,
    output logic                   list_empty,
    output logic                   last
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SORT   = 2'd1;
    localparam logic [1:0] S_DUMP   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ctr_reg, ctr_next;

    logic             out_valid_reg;
    logic [ST_W-1:0]  status_reg, status_next;
    logic             has_value_reg, has_value_next;
    logic [VAL_W-1:0] element_value_reg, element_value_next;
    logic [LEN_W-1:0] list_length_reg;
    logic             list_empty_reg;
    logic             last_reg, last_next;
    logic             out_load;

    logic             can_load;
    logic             accept;
    logic [CMPW-1:0]  pos_ext, pos_m1, cnt_ext, ctr_ext;
    logic             ins_bad, ins_full, del_bad;
    logic             ins_ok, del_ok;
    logic [VAL_W-1:0] del_value;

    logic [VAL_W-1:0] cell_value [CAPACITY];
    logic             cell_gt [CAPACITY];
    cell_ctrl_t       cell_ctrl [CAPACITY];

    assign can_load = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && can_load);
    assign accept   = in_valid && !in_stall;

    assign pos_ext  = CMPW'(position);
    assign pos_m1   = pos_ext - CMPW'(1);
    assign cnt_ext  = CMPW'(count_reg);
    assign ctr_ext  = CMPW'(ctr_reg);
    assign ins_bad  = (position == '0) || (pos_ext > cnt_ext + CMPW'(1));
    assign ins_full = (cnt_ext == CMPW'(CAPACITY));
    assign del_bad  = (position == '0) || (pos_ext > cnt_ext);
    assign ins_ok   = accept && (cmd == CMD_INSERT) && !ins_bad && !ins_full;
    assign del_ok   = accept && (cmd == CMD_DELETE) && !del_bad;

    always_comb
    begin
        del_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMPW'(i) == pos_m1)
            begin
                del_value = del_value | cell_value[i];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [CMPW-1:0]  idx;
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;
        logic             left_g;
        logic             pair_right;
        logic             pair_left;

        assign idx        = CMPW'(g);
        assign pair_right = (idx + CMPW'(1) < cnt_ext) && (((g % 2) == 1) == ctr_reg[0]);

        if (g > 0)
        begin : g_left
            assign left_v    = cell_value[g-1];
            assign left_g    = cell_gt[g-1];
            assign pair_left = (idx < cnt_ext) && ((((g - 1) % 2) == 1) == ctr_reg[0]);
        end
        else
        begin : g_head
            assign left_v    = '0;
            assign left_g    = 1'b0;
            assign pair_left = 1'b0;
        end

        if (g < CAPACITY - 1)
        begin : g_right
            assign right_v = cell_value[g+1];
        end
        else
        begin : g_tail
            assign right_v = '0;
        end

        always_comb
        begin
            cell_ctrl[g].op        = CELL_HOLD;
            cell_ctrl[g].left_act  = pair_left;
            cell_ctrl[g].right_act = pair_right;
            priority if (ins_ok)
            begin
                if (idx == pos_m1)
                begin
                    cell_ctrl[g].op = CELL_LOAD;
                end
                else if (idx > pos_m1)
                begin
                    cell_ctrl[g].op = CELL_LEFT;
                end
            end
            else if (del_ok)
            begin
                if (idx >= pos_m1)
                begin
                    cell_ctrl[g].op = CELL_RIGHT;
                end
            end
            else if (state_reg == S_SORT)
            begin
                cell_ctrl[g].op = CELL_SORT;
            end
            else if ((state_reg == S_DUMP) && can_load)
            begin
                if (idx + CMPW'(1) < cnt_ext)
                begin
                    cell_ctrl[g].op = CELL_RIGHT;
                end
                else if (idx + CMPW'(1) == cnt_ext)
                begin
                    cell_ctrl[g].op = CELL_WRAP;
                end
            end
            else
            begin
                cell_ctrl[g].op = CELL_HOLD;
            end
        end

        ple_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[g]),
            .load_value  (value),
            .left_value  (left_v),
            .right_value (right_v),
            .wrap_value  (cell_value[0]),
            .left_gt     (left_g),
            .value       (cell_value[g]),
            .gt          (cell_gt[g])
        );
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        ctr_next           = ctr_reg;
        out_load           = 1'b0;
        status_next        = ST_OK;
        has_value_next     = 1'b0;
        element_value_next = '0;
        last_next          = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            out_load = 1'b1;
                            if (ins_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (ins_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            out_load = 1'b1;
                            if (del_bad)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                count_next         = count_reg - CW'(1);
                                has_value_next     = 1'b1;
                                element_value_next = del_value;
                            end
                        end
                        CMD_SORT:
                        begin
                            state_next = S_SORT;
                            ctr_next   = '0;
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                                ctr_next   = '0;
                            end
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                if (ctr_ext + CMPW'(1) >= cnt_ext)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctr_next = ctr_reg + CW'(1);
                end
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (can_load)
                begin
                    out_load           = 1'b1;
                    has_value_next     = 1'b1;
                    element_value_next = cell_value[0];
                    last_next          = (ctr_ext + CMPW'(1) == cnt_ext);
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctr_next = ctr_reg + CW'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ctr_reg   <= ctr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg        <= status_next;
            has_value_reg     <= has_value_next;
            element_value_reg <= element_value_next;
            list_length_reg   <= LEN_W'(count_next);
            list_empty_reg    <= (count_next == '0);
            last_reg          <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign has_value     = has_value_reg;
    assign element_value = element_value_reg;
    assign list_length   = list_length_reg;
    assign list_empty    = list_empty_reg;
    assign last          = last_reg;

    `PLE_ASSERT_SAME(a_count_bound, 1'b1, cnt_ext <= CMPW'(CAPACITY),
        "list length exceeds capacity")
    `PLE_ASSERT_SAME(a_busy_stalls, state_reg != S_IDLE, in_stall,
        "input taken while a command is still running")
    `PLE_ASSERT_NEXT(a_insert_grows, ins_ok, count_reg == $past(count_reg) + CW'(1),
        "successful insert did not grow the list")
    `PLE_ASSERT_SAME(a_dump_carries, out_valid_reg && !last_reg, has_value_reg,
        "non-final dump word carries no element")

endmodule

`default_nettype wire
